// ===== rtl/sbce_pkg.sv =====
// ----------------------------------------------------------------------------
// sbce_pkg
// Shared types and constants for the sixteen-bit CPU execute block.
// ----------------------------------------------------------------------------
package sbce_pkg;

  localparam int DATA_W            = 16;
  localparam int REG_IDX_W         = 4;
  localparam int NUM_REGS          = 1 << REG_IDX_W;
  localparam int ADDR_BITS_DEFAULT = 16;

  localparam logic [DATA_W-1:0] MAJ_MATCH  = 16'h000F;
  localparam logic [DATA_W-1:0] PC_STEP    = 16'h0001;
  localparam logic [DATA_W-1:0] CMP_TRUE   = 16'h0001;
  localparam logic [DATA_W-1:0] CMP_FALSE  = 16'h0000;

  typedef enum logic [3:0] {
    OP_LOD = 4'd0,
    OP_ADD = 4'd1,
    OP_SUB = 4'd2,
    OP_AND = 4'd3,
    OP_OR  = 4'd4,
    OP_XOR = 4'd5,
    OP_SHR = 4'd6,
    OP_MUL = 4'd7,
    OP_STO = 4'd8,
    OP_LDC = 4'd9,
    OP_GTU = 4'd10,
    OP_GTS = 4'd11,
    OP_LTU = 4'd12,
    OP_LTS = 4'd13,
    OP_EQU = 4'd14,
    OP_MAJ = 4'd15
  } opcode_t;

  typedef enum logic [1:0] {
    SHM_ASR = 2'd0,
    SHM_LSR = 2'd1,
    SHM_ROL = 2'd2,
    SHM_LSL = 2'd3
  } shift_mode_t;

  typedef enum logic [0:0] {
    KIND_PRELOAD = 1'b0,
    KIND_EXEC    = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    data;
  } rf_wr_t;

  typedef struct packed {
    logic              en;
    logic [DATA_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } dm_wr_t;

endpackage

// ===== rtl/sbce_if.sv =====
// ----------------------------------------------------------------------------
// sbce_in_if / sbce_out_if
// Valid/ready channels for instruction items and result items.
// ----------------------------------------------------------------------------
interface sbce_in_if;
  import sbce_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [3:0]           opcode;
  logic [REG_IDX_W-1:0] dest_index;
  logic [REG_IDX_W-1:0] first_source;
  logic [REG_IDX_W-1:0] second_source;
  logic [DATA_W-1:0]    load_address;
  logic [DATA_W-1:0]    load_value;

  modport source (
    output valid, kind, opcode, dest_index, first_source, second_source,
           load_address, load_value,
    input  ready
  );

  modport sink (
    input  valid, kind, opcode, dest_index, first_source, second_source,
           load_address, load_value,
    output ready
  );
endinterface

interface sbce_out_if;
  import sbce_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [DATA_W-1:0]    next_pc;
  logic                 halted;
  logic                 reg_written;
  logic [REG_IDX_W-1:0] written_reg;
  logic [DATA_W-1:0]    written_value;
  logic                 mem_written;

  modport source (
    output valid, next_pc, halted, reg_written, written_reg, written_value,
           mem_written,
    input  ready
  );

  modport sink (
    input  valid, next_pc, halted, reg_written, written_reg, written_value,
           mem_written,
    output ready
  );
endinterface

// ===== rtl/sixteen_bit_cpu_execute.sv =====
// ----------------------------------------------------------------------------
// sixteen_bit_cpu_execute
// Execute stage of a 16-register, 16-bit machine with data memory and pc.
// ----------------------------------------------------------------------------
// Each item is read in its transfer cycle from the register file and data
// memory (both synchronous, registered reads); in ST_EXEC the result is
// computed, and register file, data memory and pc written back. One item is
// in flight at a time; a result waiting in the output register stalls the
// write-back cycle of the following item. After reset the data memory is
// swept to zero, one word per cycle, during which no instruction is accepted;
// program_length may be written meanwhile.
// ----------------------------------------------------------------------------
module sixteen_bit_cpu_execute #(
  parameter int ADDR_BITS = sbce_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [sbce_pkg::DATA_W-1:0] cfg_data,
  sbce_in_if.sink                     instr,
  sbce_out_if.source                  result
);
  import sbce_pkg::*;

  state_t               state;
  state_t               state_next;
  logic                 in_ready;
  logic                 exec_active;
  logic                 in_fire;
  logic                 out_free;
  logic                 commit;
  logic                 dm_busy;

  logic [DATA_W-1:0]    pc;
  logic [DATA_W-1:0]    prog_len;

  kind_t                kind;
  opcode_t              opcode;
  logic [REG_IDX_W-1:0] dest;
  logic [REG_IDX_W-1:0] src1;
  logic [REG_IDX_W-1:0] src2;
  logic [DATA_W-1:0]    ld_addr;
  logic [DATA_W-1:0]    ld_val;

  logic [DATA_W-1:0]    a;
  logic [DATA_W-1:0]    b;
  logic [DATA_W-1:0]    mem_rdata;
  logic [DATA_W-1:0]    alu_val;
  logic                 run;
  logic                 mw;
  logic [DATA_W-1:0]    pc_next;
  logic [DATA_W-1:0]    b_after;

  rf_wr_t               rf_wr;
  dm_wr_t               dm_wr;

  assign in_fire  = instr.valid & in_ready;
  assign out_free = ~result.valid | result.ready;
  assign commit   = exec_active & out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (!dm_busy)     state_next = ST_IDLE;
      ST_IDLE:  if (instr.valid)  state_next = ST_EXEC;
      ST_EXEC:  if (out_free)     state_next = ST_IDLE;
      default:                    state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready    = (state == ST_IDLE);
    exec_active = (state == ST_EXEC);
  end

  assign instr.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      prog_len <= '0;
      pc       <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        prog_len <= cfg_data;
      end
      if (commit) begin
        pc <= pc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind    <= kind_t'(instr.kind);
      opcode  <= opcode_t'(instr.opcode);
      dest    <= instr.dest_index;
      src1    <= instr.first_source;
      src2    <= instr.second_source;
      ld_addr <= instr.load_address;
      ld_val  <= instr.load_value;
    end
  end

  sbce_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (in_fire),
    .rd_addr_a (instr.first_source),
    .rd_addr_b (instr.second_source),
    .rd_data_a (a),
    .rd_data_b (b),
    .wr        (rf_wr)
  );

  sbce_dmem #(
    .ADDR_BITS (ADDR_BITS)
  ) u_dmem (
    .clk     (clk),
    .rst     (rst),
    .busy    (dm_busy),
    .rd_en   (in_fire),
    .rd_addr (ADDR_BITS'(instr.second_source)),
    .rd_data (mem_rdata),
    .wr      (dm_wr)
  );

  sbce_alu u_alu (
    .opcode        (opcode),
    .a             (a),
    .b             (b),
    .first_source  (src1),
    .second_source (src2),
    .mem_data      (mem_rdata),
    .value         (alu_val)
  );

  // MAJ: dest gets a, so register src1 reads a afterwards; src2 may be dest
  assign b_after = (dest == src2) ? a : b;

  always_comb begin
    run = (kind == KIND_EXEC) && (pc < prog_len);
    mw  = (kind == KIND_PRELOAD) || (run && opcode == OP_STO);
    if (!run) begin
      pc_next = pc;
    end else if (opcode == OP_MAJ && a == MAJ_MATCH) begin
      pc_next = b_after;
    end else begin
      pc_next = pc + PC_STEP;
    end
  end

  always_comb begin
    rf_wr.en   = commit & run;
    rf_wr.idx  = dest;
    rf_wr.data = alu_val;
    dm_wr.en   = commit & mw;
    dm_wr.addr = (kind == KIND_PRELOAD) ? ld_addr : b;
    dm_wr.data = (kind == KIND_PRELOAD) ? ld_val : a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (commit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result.next_pc       <= pc_next;
      result.halted        <= (pc_next >= prog_len);
      result.reg_written   <= run;
      result.written_reg   <= run ? dest : '0;
      result.written_value <= run ? alu_val : '0;
      result.mem_written   <= mw;
    end
  end

endmodule

// ===== rtl/sbce_regfile.sv =====
// ----------------------------------------------------------------------------
// sbce_regfile
// 16 x 16 register file, two registered read ports, one write port.
// Per-entry valid bits make unwritten registers read as zero after reset.
// ----------------------------------------------------------------------------
module sbce_regfile (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           rd_en,
  input  logic [sbce_pkg::REG_IDX_W-1:0] rd_addr_a,
  input  logic [sbce_pkg::REG_IDX_W-1:0] rd_addr_b,
  output logic [sbce_pkg::DATA_W-1:0]    rd_data_a,
  output logic [sbce_pkg::DATA_W-1:0]    rd_data_b,
  input  sbce_pkg::rf_wr_t               wr
);
  import sbce_pkg::*;

  logic [DATA_W-1:0]   mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld;
  logic [DATA_W-1:0]   data_a;
  logic [DATA_W-1:0]   data_b;
  logic                vld_a;
  logic                vld_b;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
    if (rd_en) begin
      data_a <= mem[rd_addr_a];
      data_b <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_a <= 1'b0;
      vld_b <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.idx] <= 1'b1;
      end
      if (rd_en) begin
        vld_a <= vld[rd_addr_a];
        vld_b <= vld[rd_addr_b];
      end
    end
  end

  assign rd_data_a = vld_a ? data_a : '0;
  assign rd_data_b = vld_b ? data_b : '0;

endmodule

// ===== rtl/sbce_dmem.sv =====
// ----------------------------------------------------------------------------
// sbce_dmem
// Word-addressed data memory, one write and one registered read port.
// Sweeps zeros through every word after reset; busy while sweeping.
// ----------------------------------------------------------------------------
module sbce_dmem #(
  parameter int ADDR_BITS = sbce_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  output logic                        busy,
  input  logic                        rd_en,
  input  logic [ADDR_BITS-1:0]        rd_addr,
  output logic [sbce_pkg::DATA_W-1:0] rd_data,
  input  sbce_pkg::dm_wr_t            wr
);
  import sbce_pkg::*;

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [DATA_W-1:0]    mem [DEPTH];
  logic [ADDR_BITS-1:0] clr_addr;
  logic                 clearing;
  logic                 we;
  logic [ADDR_BITS-1:0] waddr;
  logic [DATA_W-1:0]    wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == {ADDR_BITS{1'b1}}) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + ADDR_BITS'(1);
    end
  end

  always_comb begin
    we    = clearing | wr.en;
    waddr = clearing ? clr_addr : wr.addr[ADDR_BITS-1:0];
    wdata = clearing ? '0 : wr.data;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign busy = clearing;

endmodule

// ===== rtl/sbce_alu.sv =====
// ----------------------------------------------------------------------------
// sbce_alu
// Result value of one instruction from its operands.
// ----------------------------------------------------------------------------
module sbce_alu (
  input  sbce_pkg::opcode_t              opcode,
  input  logic [sbce_pkg::DATA_W-1:0]    a,
  input  logic [sbce_pkg::DATA_W-1:0]    b,
  input  logic [sbce_pkg::REG_IDX_W-1:0] first_source,
  input  logic [sbce_pkg::REG_IDX_W-1:0] second_source,
  input  logic [sbce_pkg::DATA_W-1:0]    mem_data,
  output logic [sbce_pkg::DATA_W-1:0]    value
);
  import sbce_pkg::*;

  logic [2*DATA_W-1:0] prod;
  logic [2*DATA_W-1:0] rot;
  logic [3:0]          shamt;
  shift_mode_t         shmode;
  logic [DATA_W-1:0]   shifted;

  assign prod   = {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, b};
  assign shamt  = b[3:0];
  assign shmode = shift_mode_t'(b[5:4]);
  assign rot    = {a, a} << shamt;

  always_comb begin
    unique case (shmode)
      SHM_ASR: shifted = DATA_W'($signed(a) >>> shamt);
      SHM_LSR: shifted = a >> shamt;
      SHM_ROL: shifted = rot[2*DATA_W-1:DATA_W];
      SHM_LSL: shifted = a << shamt;
    endcase
  end

  always_comb begin
    unique case (opcode)
      OP_LOD: value = mem_data;
      OP_ADD: value = a + b;
      OP_SUB: value = a - b;
      OP_AND: value = a & b;
      OP_OR:  value = a | b;
      OP_XOR: value = a ^ b;
      OP_SHR: value = shifted;
      OP_MUL: value = prod[DATA_W-1:0];
      OP_STO: value = a;
      OP_LDC: value = DATA_W'(first_source | second_source);
      OP_GTU: value = (a > b) ? CMP_TRUE : CMP_FALSE;
      OP_GTS: value = ($signed(a) > $signed(b)) ? CMP_TRUE : CMP_FALSE;
      OP_LTU: value = (a < b) ? CMP_TRUE : CMP_FALSE;
      OP_LTS: value = ($signed(a) < $signed(b)) ? CMP_TRUE : CMP_FALSE;
      OP_EQU: value = (a == b) ? CMP_TRUE : CMP_FALSE;
      OP_MAJ: value = a;
    endcase
  end

endmodule

// ===== tb/sixteen_bit_cpu_execute_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sixteen_bit_cpu_execute_tb
// Self-checking bench for the execute stage: a short table of directed
// instructions, then random programs in phases of different program lengths.
// Every result transfer is compared against either a table entry or an in-bench
// model of the register file, data memory and program counter.
// ----------------------------------------------------------------------------
module sixteen_bit_cpu_execute_tb;
  import sbce_pkg::*;

  typedef struct packed {
    kind_t       kind;
    opcode_t     opcode;
    logic [3:0]  dest_index;
    logic [3:0]  first_source;
    logic [3:0]  second_source;
    logic [15:0] load_address;
    logic [15:0] load_value;
  } instr_item_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        halted;
    logic        reg_written;
    logic [3:0]  written_reg;
    logic [15:0] written_value;
    logic        mem_written;
  } exec_result_t;

  typedef struct packed {
    bit           is_cfg;
    logic [15:0]  cfg_value;
    instr_item_t  item;
    bit           typed;
    exec_result_t expected;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [DATA_W-1:0] cfg_data;

  sbce_in_if  instr_ch ();
  sbce_out_if result_ch ();

  sixteen_bit_cpu_execute dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .instr     (instr_ch),
    .result    (result_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // machine state as the bench sees it
  logic [15:0] arch_regs [16];
  logic [15:0] data_mem [65536];
  logic [15:0] pc_state;
  logic [15:0] prog_length;

  exec_result_t  pending_results [$];
  directed_row_t directed_rows [$];
  exec_result_t  seen_res, due_res;

  int mismatches     = 0;
  int results_seen   = 0;
  int items_sent     = 0;
  int items_counted  = 0;
  int burst_left     = 0;
  bit long_hold_done = 0;

  function automatic logic [15:0] shift_word(input logic [15:0] x, input logic [15:0] ctl);
    logic [3:0]  amount;
    shift_mode_t mode;
    logic [31:0] doubled;
    amount  = ctl[3:0];
    mode    = shift_mode_t'(ctl[5:4]);
    doubled = {x, x} << amount;
    case (mode)
      SHM_ASR: return $signed(x) >>> amount;
      SHM_LSR: return x >> amount;
      SHM_ROL: return doubled[31:16];
      default: return x << amount;
    endcase
  endfunction

  function automatic exec_result_t run_instruction(input instr_item_t it, output bit executed);
    exec_result_t r;
    logic [15:0]  a, b, val, next;
    r        = '0;
    executed = 1'b0;
    if (it.kind == KIND_PRELOAD) begin
      data_mem[it.load_address] = it.load_value;
      r.mem_written = 1'b1;
    end else if (pc_state < prog_length) begin
      executed = 1'b1;
      a    = arch_regs[it.first_source];
      b    = arch_regs[it.second_source];
      next = pc_state + PC_STEP;
      case (it.opcode)
        OP_LOD: val = data_mem[{12'h000, it.second_source}];
        OP_ADD: val = a + b;
        OP_SUB: val = a - b;
        OP_AND: val = a & b;
        OP_OR:  val = a | b;
        OP_XOR: val = a ^ b;
        OP_SHR: val = shift_word(a, b);
        OP_MUL: val = a * b;
        OP_STO: begin
          data_mem[b]   = a;
          r.mem_written = 1'b1;
          val           = a;
        end
        OP_LDC: val = {12'h000, it.first_source | it.second_source};
        OP_GTU: val = (a > b) ? CMP_TRUE : CMP_FALSE;
        OP_GTS: val = ($signed(a) > $signed(b)) ? CMP_TRUE : CMP_FALSE;
        OP_LTU: val = (a < b) ? CMP_TRUE : CMP_FALSE;
        OP_LTS: val = ($signed(a) < $signed(b)) ? CMP_TRUE : CMP_FALSE;
        OP_EQU: val = (a == b) ? CMP_TRUE : CMP_FALSE;
        default: val = a;
      endcase
      arch_regs[it.dest_index] = val;
      // MAJ looks at the registers after its own write
      if (it.opcode == OP_MAJ && arch_regs[it.first_source] == MAJ_MATCH)
        next = arch_regs[it.second_source];
      pc_state        = next;
      r.reg_written   = 1'b1;
      r.written_reg   = it.dest_index;
      r.written_value = val;
    end
    r.next_pc = pc_state;
    r.halted  = (pc_state >= prog_length);
    return r;
  endfunction

  function automatic exec_result_t res(input logic [15:0] pc, input logic h, input logic rw,
                                       input logic [3:0] wr, input logic [15:0] wv,
                                       input logic mw);
    exec_result_t r;
    r = {pc, h, rw, wr, wv, mw};
    return r;
  endfunction

  function automatic instr_item_t make_exec(input opcode_t op, input logic [3:0] d,
                                            input logic [3:0] s1, input logic [3:0] s2);
    instr_item_t it;
    it.kind          = KIND_EXEC;
    it.opcode        = op;
    it.dest_index    = d;
    it.first_source  = s1;
    it.second_source = s2;
    it.load_address  = 16'($urandom);
    it.load_value    = 16'($urandom);
    return it;
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // keep MAJ targets away from the top of the address space so pc never parks there
  function automatic instr_item_t tame_jump(input instr_item_t it);
    logic [15:0] target;
    target = (it.dest_index == it.second_source) ? arch_regs[it.first_source]
                                                 : arch_regs[it.second_source];
    if (it.opcode == OP_MAJ && arch_regs[it.first_source] == MAJ_MATCH && target > 16'hFF00)
      it.second_source = it.first_source;
    return it;
  endfunction

  function automatic instr_item_t random_instr();
    instr_item_t it;
    it = make_exec(opcode_t'($urandom_range(0, 15)), 4'($urandom), 4'($urandom),
                   4'($urandom));
    if ($urandom_range(0, 9) == 0) it.kind = KIND_PRELOAD;
    it.load_address = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
    it.load_value   = pick_word();
    if (it.kind == KIND_EXEC) it = tame_jump(it);
    return it;
  endfunction

  function automatic void row_cfg(input logic [15:0] v);
    directed_row_t row;
    row           = '0;
    row.is_cfg    = 1'b1;
    row.cfg_value = v;
    directed_rows.push_back(row);
  endfunction

  function automatic void row_ex(input opcode_t op, input logic [3:0] d, input logic [3:0] s1,
                                 input logic [3:0] s2, input bit typed = 0,
                                 input exec_result_t e = '0);
    directed_row_t row;
    row          = '0;
    row.item     = make_exec(op, d, s1, s2);
    row.typed    = typed;
    row.expected = e;
    directed_rows.push_back(row);
  endfunction

  function automatic void row_pre(input logic [15:0] addr, input logic [15:0] val,
                                  input exec_result_t e);
    directed_row_t row;
    row                   = '0;
    row.item              = make_exec(OP_LOD, 4'($urandom), 4'($urandom), 4'($urandom));
    row.item.kind         = KIND_PRELOAD;
    row.item.load_address = addr;
    row.item.load_value   = val;
    row.typed             = 1'b1;
    row.expected          = e;
    directed_rows.push_back(row);
  endfunction

  function automatic void log_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  task automatic send_instr(input instr_item_t it, input bit typed, input exec_result_t typed_res);
    int           gap;
    exec_result_t predicted;
    bit           executed;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        instr_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    instr_ch.valid         = 1'b1;
    instr_ch.kind          = it.kind;
    instr_ch.opcode        = it.opcode;
    instr_ch.dest_index    = it.dest_index;
    instr_ch.first_source  = it.first_source;
    instr_ch.second_source = it.second_source;
    instr_ch.load_address  = it.load_address;
    instr_ch.load_value    = it.load_value;
    @(posedge clk);
    while (instr_ch.ready !== 1'b1) @(posedge clk);
    predicted = run_instruction(it, executed);
    pending_results.push_back(typed ? typed_res : predicted);
    items_sent++;
    if (executed || it.kind == KIND_PRELOAD) items_counted++;
  endtask

  task automatic send_plain(input instr_item_t it);
    send_instr(it, 1'b0, '0);
  endtask

  // drop valid and let the block drain before touching the register
  task automatic settle();
    @(negedge clk);
    instr_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_program_length(input logic [15:0] v);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_data  = v;
    @(negedge clk);
    cfg_write   = 1'b0;
    prog_length = v;
  endtask

  // load 0x000F into one register and jump through another
  task automatic jump_sequence(input bit to_low);
    logic [3:0]  hold_reg, tgt_reg, tgt, part, d;
    instr_item_t it;
    hold_reg = 4'($urandom);
    tgt_reg  = hold_reg ^ 4'($urandom_range(1, 15));
    tgt      = 4'($urandom);
    part     = 4'($urandom);
    send_plain(make_exec(OP_LDC, hold_reg, part, ~part | 4'($urandom)));
    if (to_low) begin
      part = 4'($urandom) & tgt;
      d    = tgt_reg ^ 4'($urandom_range(1, 15));
      send_plain(make_exec(OP_LDC, tgt_reg, part, tgt));
      send_plain(make_exec(OP_MAJ, d, hold_reg, tgt_reg));
    end else begin
      it = make_exec(OP_MAJ, 4'($urandom), hold_reg, 4'($urandom));
      send_plain(tame_jump(it));
    end
  endtask

  always @(posedge clk) begin
    if (rst === 1'b0 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      results_seen++;
      seen_res = {result_ch.next_pc, result_ch.halted, result_ch.reg_written,
                  result_ch.written_reg, result_ch.written_value, result_ch.mem_written};
      if (pending_results.size() == 0) begin
        log_failure($sformatf("unexpected result transfer: pc=%h halt=%b rw=%b reg=%0d val=%h mw=%b",
                              seen_res.next_pc, seen_res.halted, seen_res.reg_written,
                              seen_res.written_reg, seen_res.written_value, seen_res.mem_written));
      end else begin
        due_res = pending_results.pop_front();
        if (seen_res !== due_res)
          log_failure($sformatf({"mismatch: expected pc=%h halt=%b rw=%b reg=%0d val=%h mw=%b,",
                                 " got pc=%h halt=%b rw=%b reg=%0d val=%h mw=%b"},
                                due_res.next_pc, due_res.halted, due_res.reg_written,
                                due_res.written_reg, due_res.written_value, due_res.mem_written,
                                seen_res.next_pc, seen_res.halted, seen_res.reg_written,
                                seen_res.written_reg, seen_res.written_value,
                                seen_res.mem_written));
      end
    end
  end

  // result side: stall patterns in runs, plus one long hold-off
  initial begin
    int mode;
    int run_left;
    int stall_left;
    run_left   = 0;
    stall_left = 0;
    mode       = 0;
    result_ch.ready = 1'b0;
    @(negedge clk);
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!long_hold_done && results_seen >= 60 && instr_ch.valid === 1'b1) begin
        long_hold_done = 1'b1;
        stall_left     = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready = 1'b0;
      end else begin
        if (run_left == 0) begin
          mode     = $urandom_range(0, 3);
          run_left = $urandom_range(10, 80);
        end
        run_left--;
        case (mode)
          0:       result_ch.ready = 1'b1;
          1:       result_ch.ready = ($urandom_range(0, 1) == 0);
          2:       result_ch.ready = ($urandom_range(0, 3) == 0);
          default: result_ch.ready = ($urandom_range(0, 6) != 0);
        endcase
      end
    end
  end

  initial begin
    #6_000_000;
    $display("[sixteen_bit_cpu_execute] ERROR");
    $finish;
  end

  initial begin
    logic [15:0] new_len;
    int          phase_len, steps, after_halt, rem;
    rst                    = 1'b1;
    cfg_write              = 1'b0;
    cfg_data               = '0;
    instr_ch.valid         = 1'b0;
    instr_ch.kind          = KIND_PRELOAD;
    instr_ch.opcode        = OP_LOD;
    instr_ch.dest_index    = '0;
    instr_ch.first_source  = '0;
    instr_ch.second_source = '0;
    instr_ch.load_address  = '0;
    instr_ch.load_value    = '0;
    foreach (arch_regs[i]) arch_regs[i] = '0;
    foreach (data_mem[i]) data_mem[i] = '0;
    pc_state    = '0;
    prog_length = '0;

    row_cfg(16'h0000);
    row_ex(OP_ADD, 1, 2, 3, 1, res(0, 1, 0, 0, 16'h0000, 0));
    row_pre(16'h0005, 16'hFFFF, res(0, 1, 0, 0, 16'h0000, 1));
    row_cfg(16'hFFFF);
    row_ex(OP_LDC, 1, 15, 0, 1, res(1, 0, 1, 1, 16'h000F, 0));
    row_ex(OP_LDC, 4, 0, 1, 1, res(2, 0, 1, 4, 16'h0001, 0));
    row_ex(OP_SUB, 15, 0, 4, 1, res(3, 0, 1, 15, 16'hFFFF, 0));
    row_ex(OP_LOD, 5, 0, 5, 1, res(4, 0, 1, 5, 16'hFFFF, 0));
    row_ex(OP_ADD, 6, 15, 15);
    row_ex(OP_MUL, 7, 15, 15);
    row_ex(OP_LDC, 8, 8, 0);
    row_ex(OP_ADD, 9, 8, 8);
    row_ex(OP_OR, 10, 9, 1);
    row_ex(OP_ADD, 11, 10, 9);
    row_ex(OP_SHR, 12, 6, 8);   // arithmetic, negative value
    row_ex(OP_SHR, 12, 6, 10);  // logical by 15
    row_ex(OP_SHR, 12, 6, 11);  // rotate left by 15
    row_ex(OP_SHR, 12, 4, 15);  // shift left by 15
    row_ex(OP_XOR, 2, 6, 15);
    row_ex(OP_AND, 2, 15, 10);
    row_ex(OP_STO, 3, 6, 1);
    row_ex(OP_GTU, 2, 15, 4);
    row_ex(OP_GTS, 2, 15, 4);
    row_ex(OP_LTU, 2, 4, 15);
    row_ex(OP_LTS, 2, 4, 15);
    row_ex(OP_EQU, 2, 6, 3);
    row_ex(OP_MAJ, 2, 1, 4);    // taken
    row_ex(OP_MAJ, 2, 4, 1);    // not taken
    row_cfg(16'h0003);
    row_ex(OP_LDC, 1, 0, 0, 1, res(3, 1, 1, 1, 16'h0000, 0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        settle();
        set_program_length(directed_rows[i].cfg_value);
      end else begin
        send_instr(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].expected);
      end
    end

    while (items_counted < 1150 && items_sent < 4000) begin
      settle();
      case ($urandom_range(0, 9))
        0:       new_len = 16'h0000;
        1:       new_len = 16'h0001;
        2:       new_len = 16'h0002;
        3, 4:    new_len = 16'($urandom_range(3, 40));
        5, 6:    new_len = 16'($urandom_range(41, 3000));
        7:       new_len = 16'hFFFE;
        default: new_len = 16'hFFFF;
      endcase
      if (pc_state >= new_len && pc_state >= 16) new_len = 16'hFFFF;
      set_program_length(new_len);
      phase_len  = $urandom_range(20, 120);
      steps      = 0;
      after_halt = 0;
      while (steps < phase_len && after_halt < 4) begin
        rem = int'(prog_length) - int'(pc_state);
        if (rem <= 0) begin
          send_plain(random_instr());
          after_halt++;
          steps++;
        end else if (rem == 3 && $urandom_range(0, 3) != 0) begin
          jump_sequence(1'b1);
          steps += 3;
        end else if (rem > 3 && steps >= phase_len - 3) begin
          jump_sequence(1'b1);
          steps = phase_len;
        end else if (rem >= 2 && $urandom_range(0, 19) == 0) begin
          jump_sequence(1'b0);
          steps += 2;
        end else begin
          send_plain(random_instr());
          steps++;
        end
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[sixteen_bit_cpu_execute] OK");
    end else begin
      $display("[sixteen_bit_cpu_execute] ERROR");
    end
    $finish;
  end

endmodule
